[design/set_assoc_lru_cache_model_assert.svh]
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model_assert.svh
// assertion macros for the set-associative lru cache model
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_CACHE_MODEL_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_MODEL_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property must hold on every clock edge outside reset
`define SALC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("salc assertion failed");

// expression must never be true outside reset
`define SALC_ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("salc forbidden condition seen");

`else

`define SALC_ASSERT(lbl, prop)
`define SALC_ASSERT_NEVER(lbl, expr)

`endif

`endif

[design/salc_pkg.sv]
// ----------------------------------------------------------------------------
// salc_pkg
// shared types and constants of the set-associative lru cache model
// ----------------------------------------------------------------------------
package salc_pkg;

	// access kinds
	localparam logic [1:0] KIND_LOAD   = 2'd0;
	localparam logic [1:0] KIND_STORE  = 2'd1;
	localparam logic [1:0] KIND_MODIFY = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_SET_BITS   = 2'd0;
	localparam logic [1:0] REG_WAYS       = 2'd1;
	localparam logic [1:0] REG_BLOCK_BITS = 2'd2;

	localparam int KIND_W       = 2;
	localparam int CFG_INDEX_W  = 2;
	localparam int CFG_DATA_W   = 5;
	localparam int SET_BITS_W   = 3;
	localparam int WAYS_W       = 4;
	localparam int BLOCK_BITS_W = 5;
	localparam int TOTAL_W      = 32;

	localparam logic [SET_BITS_W-1:0]   SET_BITS_RST   = 3'd4;
	localparam logic [WAYS_W-1:0]       WAYS_RST       = 4'd1;
	localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST = 5'd0;

	localparam int OUT_FIELDS_W = 2 + 3 * TOTAL_W;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

	// sequencer commands to the way unit
	typedef struct packed {
		logic clear;
		logic scan_step;
		logic upd_step;
	} unit_ctrl_t;

endpackage

[design/salc_ram.sv]
// ----------------------------------------------------------------------------
// salc_ram
// simple dual-port line store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module salc_ram #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 35,
	parameter int AW    = 7
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[design/salc_unit.sv]
// ----------------------------------------------------------------------------
// salc_unit
// shared way unit: tag compare and rank compare, one way per step;
// collects hit, lru and free-way results while scanning a set and
// computes the aged rank of each way while updating it
// ----------------------------------------------------------------------------
module salc_unit #(
	parameter int TAG_W    = 32,
	parameter int WAY_W    = 3,
	parameter int CNT_W    = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  salc_pkg::unit_ctrl_t ctrl,
	input  logic [WAY_W-1:0]     way,
	input  logic                 line_valid,
	input  logic [TAG_W-1:0]     line_tag,
	input  logic [WAY_W-1:0]     line_rank,
	input  logic [TAG_W-1:0]     search_tag,
	input  logic [WAY_W-1:0]     pick_way,
	input  logic [WAY_W:0]       limit,
	output logic                 found,
	output logic [WAY_W-1:0]     found_way,
	output logic [WAY_W-1:0]     found_rank,
	output logic [CNT_W-1:0]     count,
	output logic [WAY_W-1:0]     lru_way,
	output logic [WAY_W-1:0]     lru_rank,
	output logic                 free_found,
	output logic [WAY_W-1:0]     free_way,
	output logic [WAY_W-1:0]     new_rank
);

	logic             found_q;
	logic [WAY_W-1:0] found_way_q;
	logic [WAY_W-1:0] found_rank_q;
	logic [CNT_W-1:0] count_q;
	logic [WAY_W-1:0] lru_way_q;
	logic [WAY_W-1:0] lru_rank_q;
	logic             free_found_q;
	logic [WAY_W-1:0] free_way_q;
	logic [WAY_W:0]   cmp_ref;
	logic             rank_ge;
	logic             tag_eq;

	// one rank comparator, shared by the lru search and the aging pass
	always_comb begin
		cmp_ref = ctrl.upd_step ? limit : {1'b0, lru_rank_q};
		rank_ge = {1'b0, line_rank} >= cmp_ref;
		tag_eq  = line_tag == search_tag;
		if (way == pick_way) begin
			new_rank = '0;
		end else if (line_valid && !rank_ge) begin
			new_rank = line_rank + WAY_W'(1);
		end else begin
			new_rank = line_rank;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q      <= 1'b0;
			found_way_q  <= '0;
			found_rank_q <= '0;
			count_q      <= '0;
			lru_way_q    <= '0;
			lru_rank_q   <= '0;
			free_found_q <= 1'b0;
			free_way_q   <= '0;
		end else if (ctrl.clear) begin
			found_q      <= 1'b0;
			found_way_q  <= '0;
			found_rank_q <= '0;
			count_q      <= '0;
			lru_way_q    <= '0;
			lru_rank_q   <= '0;
			free_found_q <= 1'b0;
			free_way_q   <= '0;
		end else if (ctrl.scan_step) begin
			if (line_valid) begin
				count_q <= count_q + CNT_W'(1);
				if (tag_eq && !found_q) begin
					found_q      <= 1'b1;
					found_way_q  <= way;
					found_rank_q <= line_rank;
				end
				if (rank_ge) begin
					lru_rank_q <= line_rank;
					lru_way_q  <= way;
				end
			end else if (!free_found_q) begin
				free_found_q <= 1'b1;
				free_way_q   <= way;
			end
		end
	end

	assign found      = found_q;
	assign found_way  = found_way_q;
	assign found_rank = found_rank_q;
	assign count      = count_q;
	assign lru_way    = lru_way_q;
	assign lru_rank   = lru_rank_q;
	assign free_found = free_found_q;
	assign free_way   = free_way_q;

endmodule

[design/set_assoc_lru_cache_model.sv]
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model
// set-associative cache tag array with lru replacement and running totals
// ----------------------------------------------------------------------------
//  channel  signals                           role
//  s_       tvalid tready tdata tuser         access in (address, kind)
//  m_       tvalid tready tdata tlast         access result and totals
//  cfg_     valid ready index data            register write
//
//  an access runs address split, a tag scan of every way through the registered
//  read port, the decision, a rank write-back of every way and the result load;
//  a load or store item runs one access, a modify item runs two accesses.
//  kind 3 items are accepted and give no result.
//  reset clears valid bits, totals and registers at once; no clearing pass.
//  a result waits in the output register; the next access stops at its
//  result load until that register is free.
// ----------------------------------------------------------------------------
`include "set_assoc_lru_cache_model_assert.svh"

module set_assoc_lru_cache_model #(
	parameter int MAX_SET_BITS = 4,
	parameter int MAX_WAYS     = 8,
	parameter int ADDRESS_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// address
	input  logic [((ADDRESS_BITS + 7) / 8) * 8-1:0] s_tdata,
	// kind
	input  logic [salc_pkg::KIND_W-1:0]           s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// access_hit, access_evicted, total_hits, total_misses, total_evictions
	output logic [salc_pkg::OUT_DATA_W-1:0]       m_tdata,
	output logic                                  m_tlast,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [salc_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [salc_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int NUM_SETS  = 1 << MAX_SET_BITS;
	localparam int NUM_LINES = NUM_SETS * MAX_WAYS;
	localparam int SET_W     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int CNT_W     = $clog2(MAX_WAYS + 1);
	localparam int LINE_W    = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
	localparam int ENTRY_W   = ADDRESS_BITS + WAY_W;
	localparam int TW        = salc_pkg::TOTAL_W;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_SPLIT  = 6'b000010,
		S_SCAN   = 6'b000100,
		S_DECIDE = 6'b001000,
		S_UPDATE = 6'b010000,
		S_EMIT   = 6'b100000
	} state_t;

	function automatic logic [LINE_W-1:0] line_of(input logic [SET_W-1:0] s,
		input logic [WAY_W-1:0] w);
		return LINE_W'(int'(s) * MAX_WAYS + int'(w));
	endfunction

	state_t                               state_q;
	logic [CNT_W-1:0]                     cnt_q;
	logic                                 second_q;
	logic [TW-1:0]                        hit_count_q;
	logic [TW-1:0]                        miss_count_q;
	logic [TW-1:0]                        evict_count_q;
	logic                                 m_tvalid_q;
	logic [salc_pkg::SET_BITS_W-1:0]      set_bits_q;
	logic [salc_pkg::WAYS_W-1:0]          ways_q;
	logic [salc_pkg::BLOCK_BITS_W-1:0]    block_bits_q;
	logic [NUM_LINES-1:0]                 valid_q;

	logic [ADDRESS_BITS-1:0]              addr_q;
	logic [SET_W-1:0]                     set_q;
	logic [ADDRESS_BITS-1:0]              tag_q;
	logic                                 hit_q;
	logic                                 evict_q;
	logic [WAY_W-1:0]                     pick_q;
	logic [WAY_W:0]                       limit_q;
	logic                                 write_tag_q;
	logic                                 out_hit_q;
	logic                                 out_evict_q;
	logic                                 out_last_q;
	logic [TW-1:0]                        out_hits_q;
	logic [TW-1:0]                        out_misses_q;
	logic [TW-1:0]                        out_evicts_q;

	logic [2:0]                           sb;
	logic [ADDRESS_BITS-1:0]              set_full;
	logic [SET_W-1:0]                     set_mask;
	logic [SET_W-1:0]                     set_d;
	logic [5:0]                           tag_sh;
	logic [ADDRESS_BITS-1:0]              tag_d;
	logic [4:0]                           nw;
	logic [WAY_W-1:0]                     rd_way;
	logic [CNT_W-1:0]                     cnt_m1;
	logic [WAY_W-1:0]                     prev_way;
	logic [LINE_W-1:0]                    rd_line;
	logic [LINE_W-1:0]                    wr_line;
	logic                                 last_cnt;
	logic                                 evict_cond;
	logic                                 emit_ok;
	logic                                 in_fire;
	logic [TW-1:0]                        acc_total;
	salc_pkg::unit_ctrl_t                 ctrl;

	logic [ENTRY_W-1:0]                   mem_rdata;
	logic [ENTRY_W-1:0]                   mem_wdata;
	logic [ADDRESS_BITS-1:0]              line_tag;
	logic [WAY_W-1:0]                     line_rank;
	logic                                 line_valid;

	logic                                 u_found;
	logic [WAY_W-1:0]                     u_found_way;
	logic [WAY_W-1:0]                     u_found_rank;
	logic [CNT_W-1:0]                     u_count;
	logic [WAY_W-1:0]                     u_lru_way;
	logic [WAY_W-1:0]                     u_lru_rank;
	logic                                 u_free_found;
	logic [WAY_W-1:0]                     u_free_way;
	logic [WAY_W-1:0]                     u_new_rank;

	// address split and geometry clamps
	always_comb begin
		sb       = (int'(set_bits_q) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : set_bits_q;
		set_full = addr_q >> block_bits_q;
		set_mask = ~({SET_W{1'b1}} << sb);
		set_d    = set_full[SET_W-1:0] & set_mask;
		tag_sh   = 6'(sb) + 6'(block_bits_q);
		tag_d    = addr_q >> tag_sh;
		if (ways_q == '0) begin
			nw = 5'd1;
		end else if (int'(ways_q) > MAX_WAYS) begin
			nw = 5'(MAX_WAYS);
		end else begin
			nw = 5'(ways_q);
		end
	end

	// way sequencing
	always_comb begin
		rd_way     = (int'(cnt_q) < MAX_WAYS) ? cnt_q[WAY_W-1:0] : '0;
		cnt_m1     = cnt_q - CNT_W'(1);
		prev_way   = cnt_m1[WAY_W-1:0];
		rd_line    = line_of(set_q, rd_way);
		wr_line    = line_of(set_q, prev_way);
		last_cnt   = int'(cnt_q) == MAX_WAYS;
		line_tag   = mem_rdata[ENTRY_W-1:WAY_W];
		line_rank  = mem_rdata[WAY_W-1:0];
		line_valid = valid_q[wr_line];
		ctrl.clear     = state_q == S_SPLIT;
		ctrl.scan_step = (state_q == S_SCAN) && (cnt_q != '0);
		ctrl.upd_step  = (state_q == S_UPDATE) && (cnt_q != '0);
		mem_wdata  = {(write_tag_q && prev_way == pick_q) ? tag_q : line_tag, u_new_rank};
		evict_cond = (5'(u_count) >= nw) || !u_free_found;
		emit_ok    = !m_tvalid_q || m_tready;
		in_fire    = s_tvalid && (state_q == S_IDLE);
	end

	assign acc_total = hit_count_q + miss_count_q;

	salc_ram #(
		.DEPTH (NUM_LINES),
		.WIDTH (ENTRY_W),
		.AW    (LINE_W)
	) u_ram (
		.clk   (clk),
		.we    (ctrl.upd_step),
		.waddr (wr_line),
		.wdata (mem_wdata),
		.raddr (rd_line),
		.rdata (mem_rdata)
	);

	salc_unit #(
		.TAG_W    (ADDRESS_BITS),
		.WAY_W    (WAY_W),
		.CNT_W    (CNT_W)
	) u_unit (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.way        (prev_way),
		.line_valid (line_valid),
		.line_tag   (line_tag),
		.line_rank  (line_rank),
		.search_tag (tag_q),
		.pick_way   (pick_q),
		.limit      (limit_q),
		.found      (u_found),
		.found_way  (u_found_way),
		.found_rank (u_found_rank),
		.count      (u_count),
		.lru_way    (u_lru_way),
		.lru_rank   (u_lru_rank),
		.free_found (u_free_found),
		.free_way   (u_free_way),
		.new_rank   (u_new_rank)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cnt_q         <= '0;
			second_q      <= 1'b0;
			hit_count_q   <= '0;
			miss_count_q  <= '0;
			evict_count_q <= '0;
			m_tvalid_q    <= 1'b0;
			set_bits_q    <= salc_pkg::SET_BITS_RST;
			ways_q        <= salc_pkg::WAYS_RST;
			block_bits_q  <= salc_pkg::BLOCK_BITS_RST;
			valid_q       <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					salc_pkg::REG_SET_BITS:   set_bits_q   <= cfg_data[salc_pkg::SET_BITS_W-1:0];
					salc_pkg::REG_WAYS:       ways_q       <= cfg_data[salc_pkg::WAYS_W-1:0];
					salc_pkg::REG_BLOCK_BITS: block_bits_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == S_EMIT && emit_ok) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire && s_tuser != salc_pkg::KIND_UNUSED) begin
						second_q <= s_tuser == salc_pkg::KIND_MODIFY;
						state_q  <= S_SPLIT;
					end
				end
				S_SPLIT: begin
					cnt_q   <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (last_cnt) begin
						cnt_q   <= '0;
						state_q <= S_DECIDE;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				S_DECIDE: begin
					if (u_found) begin
						hit_count_q <= hit_count_q + TW'(1);
					end else begin
						miss_count_q <= miss_count_q + TW'(1);
						if (evict_cond) begin
							evict_count_q <= evict_count_q + TW'(1);
						end else begin
							valid_q[line_of(set_q, u_free_way)] <= 1'b1;
						end
					end
					cnt_q   <= '0;
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					if (last_cnt) begin
						cnt_q   <= '0;
						state_q <= S_EMIT;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				S_EMIT: begin
					if (emit_ok) begin
						if (second_q) begin
							second_q <= 1'b0;
							state_q  <= S_SPLIT;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// access payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			addr_q <= s_tdata[ADDRESS_BITS-1:0];
		end
		if (state_q == S_SPLIT) begin
			set_q <= set_d;
			tag_q <= tag_d;
		end
		if (state_q == S_DECIDE) begin
			if (u_found) begin
				hit_q       <= 1'b1;
				evict_q     <= 1'b0;
				pick_q      <= u_found_way;
				limit_q     <= {1'b0, u_found_rank};
				write_tag_q <= 1'b0;
			end else if (evict_cond) begin
				hit_q       <= 1'b0;
				evict_q     <= 1'b1;
				pick_q      <= u_lru_way;
				limit_q     <= {1'b0, u_lru_rank};
				write_tag_q <= 1'b1;
			end else begin
				hit_q       <= 1'b0;
				evict_q     <= 1'b0;
				pick_q      <= u_free_way;
				limit_q     <= '1;
				write_tag_q <= 1'b1;
			end
		end
		if (state_q == S_EMIT && emit_ok) begin
			out_hit_q    <= hit_q;
			out_evict_q  <= evict_q;
			out_last_q   <= !second_q;
			out_hits_q   <= hit_count_q;
			out_misses_q <= miss_count_q;
			out_evicts_q <= evict_count_q;
		end
	end

	assign s_tready  = state_q == S_IDLE;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tlast   = out_last_q;
	assign m_tdata   = {{salc_pkg::OUT_PAD_W{1'b0}}, out_evicts_q, out_misses_q, out_hits_q,
		out_evict_q, out_hit_q};

	`SALC_ASSERT(a_first_of_two_keeps_busy, (m_tvalid_q && !out_last_q) |-> (state_q != S_IDLE))
	`SALC_ASSERT(a_one_total_per_access, state_q == S_DECIDE |=> acc_total == $past(acc_total) + TW'(1))
	`SALC_ASSERT_NEVER(a_evict_on_hit, m_tvalid_q && out_evict_q && out_hit_q)

endmodule
